// ----- src/lth_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lth_pkg
// Shared types and constants of the looped tape head: tape geometry, the
// stored tape word, register map, gap report codes and pipeline records.
// ----------------------------------------------------------------------------
package lth_pkg;

  // tape geometry
  localparam int unsigned TAPE_DEPTH = 131072;
  localparam int unsigned POS_W      = $clog2(TAPE_DEPTH);
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BIT_W      = 3;
  localparam int unsigned PAIR_W     = 2 * BYTE_W;

  // tape length register and its compare width
  localparam int unsigned LEN_W = 18;
  localparam int unsigned CMP_W = (LEN_W > POS_W + 1) ? LEN_W : POS_W + 1;

  // default length: 255 blocks of preamble, header, data and gap
  localparam int unsigned DEFAULT_TAPE_LENGTH = 255 * (14 + 35 + 269 + 60);

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic {
    REG_TAPE_LENGTH = 1'b0,
    REG_CARTRIDGE   = 1'b1
  } cfg_reg_e;

  // last gap level reported on the gap pin
  typedef enum logic [1:0] {
    GAP_CLEAR   = 2'd0,
    GAP_SET     = 2'd1,
    GAP_UNKNOWN = 2'd2
  } gap_e;

  typedef logic [POS_W-1:0] pos_t;

  // one tape position: erased mark and both track bytes
  typedef struct packed {
    logic              erased;
    logic [BYTE_W-1:0] track_one;
    logic [BYTE_W-1:0] track_two;
  } tape_word_t;

  localparam int unsigned TAPE_WORD_W = $bits(tape_word_t);

  localparam tape_word_t ERASED_WORD = '{erased: 1'b1, track_one: '0, track_two: '0};

  // control handed from the head stage to the report stage
  typedef struct packed {
    logic             motor_start;
    logic             nocart_gap;
    logic             read_tick;
    logic [BIT_W-1:0] tick_bit;
    logic [BIT_W-1:0] disp_bit;
    logic             selected;
    logic             write_level;
    logic             pair_taken;
    logic             modified;
    logic             fwd_hit;
    tape_word_t       fwd_word;
  } head_op_t;

  // one result item
  typedef struct packed {
    logic select_out;
    logic gap_level;
    logic gap_strobe;
    logic track_one_bit;
    logic track_two_bit;
    logic data_strobe;
    logic pair_taken;
    logic tape_modified;
  } result_t;

endpackage
`default_nettype wire

// ----- src/lth_stream_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lth_in_if / lth_out_if
// Valid/ready channels of the looped tape head: pin samples in, results out.
// ----------------------------------------------------------------------------
interface lth_in_if
  import lth_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              clk_level;
  logic              select_in;
  logic              erase_level;
  logic              write_level;
  logic              bit_tick;
  logic [PAIR_W-1:0] host_pair;

  modport source (
    output valid, clk_level, select_in, erase_level, write_level, bit_tick, host_pair,
    input  ready
  );
  modport sink (
    input  valid, clk_level, select_in, erase_level, write_level, bit_tick, host_pair,
    output ready
  );
endinterface

interface lth_out_if
  import lth_pkg::*;
();
  logic valid;
  logic ready;
  logic select_out;
  logic gap_level;
  logic gap_strobe;
  logic track_one_bit;
  logic track_two_bit;
  logic data_strobe;
  logic pair_taken;
  logic tape_modified;

  modport source (
    output valid, select_out, gap_level, gap_strobe, track_one_bit, track_two_bit,
           data_strobe, pair_taken, tape_modified,
    input  ready
  );
  modport sink (
    input  valid, select_out, gap_level, gap_strobe, track_one_bit, track_two_bit,
           data_strobe, pair_taken, tape_modified,
    output ready
  );
endinterface
`default_nettype wire

// ----- src/lth_tape_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lth_tape_ram
// Tape store: one write port and two read ports, read data registered.
// A read of the address written in the same cycle returns the old word.
// ----------------------------------------------------------------------------
module lth_tape_ram #(
  parameter  int unsigned DEPTH = 1024,
  parameter  int unsigned WIDTH = 8,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read ports, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

// ----- src/looped_tape_head_model.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// looped_tape_head_model
// One drive of a daisy-chained looped tape: select chain, motor, and a head
// that writes, erases or reads byte pairs on a circular tape.
// ----------------------------------------------------------------------------
// The block takes one pin-sample item per clock unless a clearing pass runs
// or the report stage is stalled, and returns one result item for each via
// the report stage and output registers; a result waiting at the output
// stops the next item from entering while the report stage is full too. The
// throughput of one item per cycle is set by the tape RAM, which takes one
// write (write or erase tick) and two reads (the position under the head
// before and after the item) in every cycle. After reset and every cartridge
// removal, a clearing pass writes the erased mark into all 131072 positions,
// one per cycle; no item is accepted during the pass, while register writes
// are taken throughout. The register port answers with pready always high.
// ----------------------------------------------------------------------------
module looped_tape_head_model
  import lth_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  lth_in_if.sink                     in_i,
  lth_out_if.source                  out_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  // configuration registers
  logic [LEN_W-1:0] tape_length_q, tape_length_d;
  logic             cart_q, cart_d;
  logic             cfg_we;
  cfg_reg_e         cfg_reg;

  // head state
  logic             prev_clk_q, prev_clk_d;
  logic             sel_q, sel_d;
  logic             motor_q, motor_d;
  logic [BIT_W-1:0] bit_pos_q, bit_pos_d;
  pos_t             pair_pos_q, pair_pos_d;
  logic             mod_q, mod_d;

  // clearing pass
  logic             clr_active_q, clr_active_d;
  pos_t             clr_addr_q, clr_addr_d;

  // item path
  logic             in_acc;
  logic             falling;
  logic             motor_item;
  logic             tick_act;
  logic [BIT_W-1:0] bit_item;
  pos_t             pos_item;
  logic             mod_item;
  logic [CMP_W-1:0] eff_len;
  logic [CMP_W-1:0] next_pos;
  logic             item_we;
  tape_word_t       item_wdata;
  head_op_t         op;

  // tape RAM
  logic             ram_we;
  pos_t             ram_waddr;
  tape_word_t       ram_wdata;
  tape_word_t       rd_tick, rd_disp;

  // report stage
  logic             s1_valid_q, s1_valid_d;
  head_op_t         s1_q;
  logic             b_adv;
  gap_e             rep_q, rep_d, rep_tmp;
  logic             gap_pin_q, gap_pin_d;
  tape_word_t       disp_word;
  logic             tick_gap;
  result_t          res;
  result_t          out_q;
  logic             out_valid_q, out_valid_d;

  // --------------------------------------------------------------------------
  // register port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_reg = cfg_reg_e'(paddr[CFG_ADDR_W-1]);

  // register read mux
  always_comb begin
    unique case (cfg_reg)
      REG_TAPE_LENGTH: prdata = CFG_DATA_W'(tape_length_q);
      REG_CARTRIDGE:   prdata = CFG_DATA_W'(cart_q);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  assign b_adv      = ~out_valid_q | out_o.ready;
  assign in_i.ready = ~clr_active_q & (~s1_valid_q | b_adv);
  assign in_acc     = in_i.valid & in_i.ready;

  // clamped tape length
  always_comb begin
    if (tape_length_q == '0) begin
      eff_len = CMP_W'(1);
    end else if (CMP_W'(tape_length_q) > CMP_W'(TAPE_DEPTH)) begin
      eff_len = CMP_W'(TAPE_DEPTH);
    end else begin
      eff_len = CMP_W'(tape_length_q);
    end
  end

  // --------------------------------------------------------------------------
  // head stage: chain clock, motor, tick and position update
  // --------------------------------------------------------------------------
  always_comb begin
    falling    = prev_clk_q & ~in_i.clk_level;
    sel_d      = sel_q;
    motor_item = motor_q;
    op         = '0;

    // chain clock edge comes before the tick
    if (falling) begin
      sel_d = in_i.select_in;
      if (in_i.select_in && cart_q) begin
        motor_item     = 1'b1;
        op.motor_start = 1'b1;
      end else if (in_i.select_in) begin
        op.nocart_gap = 1'b1;
      end else if (cart_q) begin
        motor_item = 1'b0;
      end
    end

    tick_act   = motor_item & in_i.bit_tick;
    item_we    = 1'b0;
    item_wdata = ERASED_WORD;
    mod_item   = mod_q;

    // write wins over erase; write only stores at bit zero
    if (tick_act) begin
      if (in_i.write_level) begin
        if (bit_pos_q == '0) begin
          item_we              = 1'b1;
          item_wdata.erased    = 1'b0;
          item_wdata.track_one = in_i.host_pair[PAIR_W-1:BYTE_W];
          item_wdata.track_two = in_i.host_pair[BYTE_W-1:0];
          mod_item             = 1'b1;
          op.pair_taken        = 1'b1;
        end
      end else if (in_i.erase_level) begin
        item_we  = 1'b1;
        mod_item = 1'b1;
      end else begin
        op.read_tick = 1'b1;
      end
    end

    // bit and pair position advance
    next_pos = CMP_W'(pair_pos_q) + CMP_W'(1);
    bit_item = bit_pos_q;
    pos_item = pair_pos_q;
    if (tick_act) begin
      bit_item = bit_pos_q + BIT_W'(1);
      if (bit_pos_q == BIT_W'(BYTE_W - 1)) begin
        pos_item = (next_pos >= eff_len) ? '0 : next_pos[POS_W-1:0];
      end
    end

    op.tick_bit    = bit_pos_q;
    op.disp_bit    = bit_item;
    op.selected    = sel_d;
    op.write_level = in_i.write_level;
    op.modified    = mod_item;
    op.fwd_hit     = item_we && (pair_pos_q == pos_item);
    op.fwd_word    = item_wdata;
  end

  // next head state, register writes applied last
  always_comb begin
    prev_clk_d    = prev_clk_q;
    motor_d       = motor_q;
    bit_pos_d     = bit_pos_q;
    pair_pos_d    = pair_pos_q;
    mod_d         = mod_q;
    tape_length_d = tape_length_q;
    cart_d        = cart_q;
    clr_active_d  = clr_active_q;
    clr_addr_d    = clr_addr_q;

    // clearing sweep
    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + POS_W'(1);
      if (clr_addr_q == POS_W'(TAPE_DEPTH - 1)) begin
        clr_active_d = 1'b0;
      end
    end

    if (in_acc) begin
      prev_clk_d = in_i.clk_level;
      motor_d    = motor_item;
      bit_pos_d  = bit_item;
      pair_pos_d = pos_item;
      mod_d      = mod_item;
    end

    if (cfg_we) begin
      unique case (cfg_reg)
        REG_TAPE_LENGTH: tape_length_d = pwdata[LEN_W-1:0];
        REG_CARTRIDGE: begin
          cart_d = pwdata[0];
          // removal stops the motor and wipes the tape
          if (cart_q && !pwdata[0]) begin
            motor_d      = 1'b0;
            mod_d        = 1'b0;
            clr_active_d = 1'b1;
            clr_addr_d   = '0;
          end else if (!cart_q && pwdata[0]) begin
            bit_pos_d  = '0;
            pair_pos_d = '0;
            mod_d      = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // head state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_clk_q    <= 1'b0;
      sel_q         <= 1'b0;
      motor_q       <= 1'b0;
      bit_pos_q     <= '0;
      pair_pos_q    <= '0;
      mod_q         <= 1'b0;
      tape_length_q <= LEN_W'(DEFAULT_TAPE_LENGTH);
      cart_q        <= 1'b1;
      clr_active_q  <= 1'b1;
      clr_addr_q    <= '0;
    end else begin
      prev_clk_q    <= prev_clk_d;
      if (in_acc) begin
        sel_q <= sel_d;
      end
      motor_q       <= motor_d;
      bit_pos_q     <= bit_pos_d;
      pair_pos_q    <= pair_pos_d;
      mod_q         <= mod_d;
      tape_length_q <= tape_length_d;
      cart_q        <= cart_d;
      clr_active_q  <= clr_active_d;
      clr_addr_q    <= clr_addr_d;
    end
  end

  // --------------------------------------------------------------------------
  // tape RAM: sweep owns the write port while clearing
  // --------------------------------------------------------------------------
  always_comb begin
    if (clr_active_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = ERASED_WORD;
    end else begin
      ram_we    = in_acc & item_we;
      ram_waddr = pair_pos_q;
      ram_wdata = item_wdata;
    end
  end

  lth_tape_ram #(
    .DEPTH (TAPE_DEPTH),
    .WIDTH (TAPE_WORD_W)
  ) u_tape_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (in_acc),
    .raddr_a_i (pair_pos_q),
    .raddr_b_i (pos_item),
    .rdata_a_o (rd_tick),
    .rdata_b_o (rd_disp)
  );

  // --------------------------------------------------------------------------
  // report stage: gap reporting and track bits from the RAM words
  // --------------------------------------------------------------------------
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (b_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= op;
    end
  end

  always_comb begin
    // same-cycle write to the displayed position is forwarded
    disp_word = s1_q.fwd_hit ? s1_q.fwd_word : rd_disp;
    tick_gap  = rd_tick.erased;
    rep_tmp   = s1_q.motor_start ? GAP_UNKNOWN : rep_q;
    rep_d     = rep_tmp;
    gap_pin_d = gap_pin_q;
    res       = '0;

    if (s1_q.nocart_gap) begin
      gap_pin_d      = 1'b1;
      res.gap_strobe = 1'b1;
    end

    // read tick: report gap changes, emit bits msb first over data
    if (s1_q.read_tick) begin
      if (gap_e'({1'b0, tick_gap}) != rep_tmp) begin
        rep_d          = gap_e'({1'b0, tick_gap});
        gap_pin_d      = tick_gap;
        res.gap_strobe = 1'b1;
      end
      if (!tick_gap) begin
        res.track_one_bit = rd_tick.track_one[~s1_q.tick_bit];
        res.track_two_bit = rd_tick.track_two[~s1_q.tick_bit];
        res.data_strobe   = 1'b1;
      end
    end

    // otherwise show the bits under the head
    if (!res.data_strobe && s1_q.selected && !s1_q.write_level && !disp_word.erased) begin
      res.track_one_bit = disp_word.track_one[~s1_q.disp_bit];
      res.track_two_bit = disp_word.track_two[~s1_q.disp_bit];
    end

    res.select_out    = s1_q.selected;
    res.gap_level     = gap_pin_d;
    res.pair_taken    = s1_q.pair_taken;
    res.tape_modified = s1_q.modified;
  end

  // gap report state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q     <= GAP_UNKNOWN;
      gap_pin_q <= 1'b0;
    end else begin
      if (s1_valid_q && b_adv) begin
        rep_q     <= rep_d;
        gap_pin_q <= gap_pin_d;
      end
      // cartridge insertion forces a fresh report
      if (cfg_we && cfg_reg == REG_CARTRIDGE && !cart_q && pwdata[0]) begin
        rep_q <= GAP_UNKNOWN;
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  assign out_valid_d = b_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && s1_valid_q) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.select_out    = out_q.select_out;
  assign out_o.gap_level     = out_q.gap_level;
  assign out_o.gap_strobe    = out_q.gap_strobe;
  assign out_o.track_one_bit = out_q.track_one_bit;
  assign out_o.track_two_bit = out_q.track_two_bit;
  assign out_o.data_strobe   = out_q.data_strobe;
  assign out_o.pair_taken    = out_q.pair_taken;
  assign out_o.tape_modified = out_q.tape_modified;

`ifndef SYNTH
  // no item enters while the sweep owns the RAM write port
  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !in_acc)
    else $error("item accepted during clearing pass");

  // a waiting item in the report stage is never overwritten
  a_s1_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!s1_valid_q || b_adv))
    else $error("report stage overrun");

  // a stalled report stage keeps its item
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !b_adv) |=> s1_valid_q)
    else $error("report stage item lost");

  // a stored pair marks the tape modified in the same result
  a_taken_modified: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.pair_taken) |-> out_q.tape_modified)
    else $error("pair stored without modified flag");

  // a write tick never emits read data
  a_write_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.pair_taken && out_q.data_strobe))
    else $error("write and read data in one item");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/lth_checker.sv -----
// ----------------------------------------------------------------------------
// lth_checker
// Watches the pin-sample and result channels and the register port of the
// looped tape head, mirrors the drive's state and tape contents, predicts
// each result item and compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
module lth_checker
  import lth_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  lth_in_if                          in_mon_i,
  lth_out_if                         out_mon_i,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic                  pready,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output int unsigned                pending_o,
  output int unsigned                errors_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  // mirrored drive state; positions never written read as erased
  tape_word_t       tape_mem [pos_t];
  logic [BIT_W-1:0] head_bit;
  pos_t             head_pos;
  logic             clk_prev;
  logic             sel_q;
  logic             motor_on;
  logic             gap_pin;
  logic             mod_flag;
  logic             cart_in;
  gap_e             gap_rep;
  logic [LEN_W-1:0] len_reg;

  result_t          expected_q [$];
  int unsigned      err_cnt;
  int unsigned      res_idx;

  function automatic tape_word_t tape_read(input pos_t p);
    return tape_mem.exists(p) ? tape_mem[p] : ERASED_WORD;
  endfunction

  // length register clamped to the physical tape
  function automatic int unsigned loop_length();
    if (len_reg == '0) return 1;
    if (len_reg > TAPE_DEPTH) return TAPE_DEPTH;
    return 32'(len_reg);
  endfunction

  // one pin sample: chain clock edge first, then the bit tick
  function automatic result_t pin_step(input logic clk_lv, input logic sel_lv,
                                       input logic erase_lv, input logic write_lv,
                                       input logic tick, input logic [PAIR_W-1:0] pair);
    result_t     r;
    tape_word_t  w;
    gap_e        gap_now;
    int unsigned nxt;
    r = '0;
    if (clk_prev && !clk_lv) begin
      sel_q = sel_lv;
      if (sel_q && cart_in) begin
        gap_rep  = GAP_UNKNOWN;
        motor_on = 1'b1;
      end else if (sel_q) begin
        // selected with no cartridge reports a gap
        gap_pin      = 1'b1;
        r.gap_strobe = 1'b1;
      end else if (cart_in) begin
        motor_on = 1'b0;
      end
    end
    clk_prev = clk_lv;

    if (motor_on && tick) begin
      w = tape_read(head_pos);
      if (write_lv) begin
        // host pair is taken only at bit zero; write wins over erase
        if (head_bit == '0) begin
          tape_mem[head_pos] = '{erased: 1'b0, track_one: pair[15:8], track_two: pair[7:0]};
          mod_flag     = 1'b1;
          r.pair_taken = 1'b1;
        end
      end else if (erase_lv) begin
        tape_mem[head_pos] = ERASED_WORD;
        mod_flag           = 1'b1;
      end else begin
        gap_now = w.erased ? GAP_SET : GAP_CLEAR;
        if (gap_now != gap_rep) begin
          gap_rep      = gap_now;
          gap_pin      = w.erased;
          r.gap_strobe = 1'b1;
        end
        if (!w.erased) begin
          r.track_one_bit = w.track_one[3'd7 - head_bit];
          r.track_two_bit = w.track_two[3'd7 - head_bit];
          r.data_strobe   = 1'b1;
        end
      end
      // advance the head, wrapping at the tape length
      head_bit = head_bit + 3'd1;
      if (head_bit == '0) begin
        nxt = 32'(head_pos) + 1;
        if (nxt >= loop_length()) nxt = 0;
        head_pos = pos_t'(nxt);
      end
    end

    // bits under the head after the item
    if (!r.data_strobe) begin
      w = tape_read(head_pos);
      if (sel_q && !write_lv && !w.erased) begin
        r.track_one_bit = w.track_one[3'd7 - head_bit];
        r.track_two_bit = w.track_two[3'd7 - head_bit];
      end
    end
    r.select_out    = sel_q;
    r.gap_level     = gap_pin;
    r.tape_modified = mod_flag;
    return r;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    result_t exp_r;
    result_t got;
    if (!rst_ni) begin
      tape_mem.delete();
      expected_q.delete();
      head_bit = '0;
      head_pos = '0;
      clk_prev = 1'b0;
      sel_q    = 1'b0;
      motor_on = 1'b0;
      gap_pin  = 1'b0;
      mod_flag = 1'b0;
      cart_in  = 1'b1;
      gap_rep  = GAP_UNKNOWN;
      len_reg  = LEN_W'(DEFAULT_TAPE_LENGTH);
      err_cnt  = 0;
      res_idx  = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (cfg_reg_e'(paddr[CFG_ADDR_W-1:2]) == REG_TAPE_LENGTH) begin
          len_reg = pwdata[LEN_W-1:0];
        end else begin
          if (cart_in && !pwdata[0]) begin
            // cartridge pulled: motor stops and the tape is wiped
            motor_on = 1'b0;
            mod_flag = 1'b0;
            tape_mem.delete();
          end else if (!cart_in && pwdata[0]) begin
            head_bit = '0;
            head_pos = '0;
            gap_rep  = GAP_UNKNOWN;
            mod_flag = 1'b0;
          end
          cart_in = pwdata[0];
        end
      end

      // compare a result item against the oldest prediction
      if (out_mon_i.valid && out_mon_i.ready) begin
        got = '{select_out:    out_mon_i.select_out,
                gap_level:     out_mon_i.gap_level,
                gap_strobe:    out_mon_i.gap_strobe,
                track_one_bit: out_mon_i.track_one_bit,
                track_two_bit: out_mon_i.track_two_bit,
                data_strobe:   out_mon_i.data_strobe,
                pair_taken:    out_mon_i.pair_taken,
                tape_modified: out_mon_i.tape_modified};
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_LIMIT)
            $display("result item %0d arrived with nothing expected: %b", res_idx, got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            err_cnt++;
            if (err_cnt <= REPORT_LIMIT) begin
              $display("result item %0d mismatch (sel gap gstb t1 t2 dstb taken mod)", res_idx);
              $display("  expected %b %b %b %b %b %b %b %b", exp_r.select_out,
                       exp_r.gap_level, exp_r.gap_strobe, exp_r.track_one_bit,
                       exp_r.track_two_bit, exp_r.data_strobe, exp_r.pair_taken,
                       exp_r.tape_modified);
              $display("  actual   %b %b %b %b %b %b %b %b", got.select_out,
                       got.gap_level, got.gap_strobe, got.track_one_bit,
                       got.track_two_bit, got.data_strobe, got.pair_taken,
                       got.tape_modified);
            end
          end
        end
        res_idx++;
      end

      // predict for each accepted pin sample, appended at the tail
      if (in_mon_i.valid && in_mon_i.ready)
        expected_q.insert(expected_q.size(),
                          pin_step(in_mon_i.clk_level, in_mon_i.select_in,
                                   in_mon_i.erase_level, in_mon_i.write_level,
                                   in_mon_i.bit_tick, in_mon_i.host_pair));
    end
    pending_o <= expected_q.size();
    errors_o  <= err_cnt;
  end

endmodule

// ----- tb/sv/tb_looped_tape_head_model.sv -----
// ----------------------------------------------------------------------------
// tb_looped_tape_head_model
// Drives pin samples and register writes into the looped tape head through
// phases of tape length and cartridge state, with random gaps on both
// channels, and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module tb_looped_tape_head_model
  import lth_pkg::*;
();

  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned STALL_LIMIT  = 3 * TAPE_DEPTH;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  hold_req;
  logic                  calm;
  logic                  cur_clk;
  int unsigned           sent_cnt;
  int unsigned           pending_cnt;
  int unsigned           error_cnt;
  int unsigned           idle_cycles;

  lth_in_if  in_if ();
  lth_out_if out_if ();

  looped_tape_head_model u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lth_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon_i  (in_if),
    .out_mon_i (out_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pending_o (pending_cnt),
    .errors_o  (error_cnt)
  );

  always #1 clk_i = ~clk_i;

  // watchdog: no item moving on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random ready with bursts, short and long stalls
  initial begin : result_sink
    int unsigned pick;
    int unsigned span;
    logic        hold_done;
    out_if.ready = 1'b0;
    hold_done    = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        // long hold-off so the block fills up and stalls its input
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (calm) begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60)      span = $urandom_range(1, 20);
        else if (pick < 92) span = $urandom_range(1, 3);
        else                span = $urandom_range(15, 60);
        out_if.ready <= (pick < 60);
        repeat (span) @(posedge clk_i);
      end
    end
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // offer one pin sample, after an optional gap, and wait for acceptance
  task automatic send_pins(input logic clk_lv, input logic sel_lv, input logic erase_lv,
                           input logic write_lv, input logic tick,
                           input logic [PAIR_W-1:0] pair);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (!calm && pick >= 70) begin
      in_if.valid <= 1'b0;
      repeat (pick >= 96 ? $urandom_range(10, 40) : $urandom_range(1, 3)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.clk_level   <= clk_lv;
    in_if.select_in   <= sel_lv;
    in_if.erase_level <= erase_lv;
    in_if.write_level <= write_lv;
    in_if.bit_tick    <= tick;
    in_if.host_pair   <= pair;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    cur_clk = clk_lv;
    sent_cnt++;
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random tape traffic: select pulses, write, erase and read bursts, noise
  task automatic run_tape_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned span;
    stop_at = sent_cnt + count;
    while (sent_cnt < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_pins(1'b1, coin(), coin(), coin(), coin(), 16'($urandom));
        send_pins(1'b0, $urandom_range(0, 7) != 0, 1'b0, 1'b0, coin(), 16'($urandom));
      end else if (pick < 45) begin
        span = $urandom_range(8, 24);
        repeat (span)
          send_pins(cur_clk, coin(), coin(), 1'b1, $urandom_range(0, 9) != 0, 16'($urandom));
      end else if (pick < 60) begin
        span = $urandom_range(4, 16);
        repeat (span)
          send_pins(cur_clk, coin(), 1'b1, 1'b0, $urandom_range(0, 9) != 0, 16'($urandom));
      end else if (pick < 90) begin
        span = $urandom_range(8, 40);
        repeat (span)
          send_pins(cur_clk, coin(), 1'b0, 1'b0, $urandom_range(0, 6) != 0, 16'($urandom));
      end else begin
        span = $urandom_range(1, 4);
        repeat (span) send_pins(coin(), coin(), coin(), coin(), coin(), 16'($urandom));
      end
    end
  endtask

  // chain clock pulse with a chosen select level
  task automatic clock_select(input logic sel_lv);
    send_pins(1'b1, sel_lv, 1'b0, 1'b0, 1'b0, 16'($urandom));
    send_pins(1'b0, sel_lv, 1'b0, 1'b0, 1'b0, 16'($urandom));
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.clk_level   = 1'b0;
    in_if.select_in   = 1'b0;
    in_if.erase_level = 1'b0;
    in_if.write_level = 1'b0;
    in_if.bit_tick    = 1'b0;
    in_if.host_pair   = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    hold_req          = 1'b0;
    calm              = 1'b0;
    cur_clk           = 1'b0;
    sent_cnt          = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: default tape, motor off, select, read, erase, write
    send_pins(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'h0000);   // tick ignored, motor stopped
    clock_select(1'b0);                                  // deselect keeps motor off
    clock_select(1'b1);                                  // motor start
    send_pins(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 16'hFFFF);   // first gap report
    repeat (4) send_pins(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 16'($urandom));
    repeat (3) send_pins(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 16'($urandom));
    send_pins(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 16'hFFFF);   // pair taken at bit zero
    send_pins(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 16'h0000);   // write wins over erase
    repeat (6) send_pins(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 16'($urandom));
    send_pins(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 16'h0000);
    send_pins(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 16'hFFFF);   // read back zeros, gap clears
    send_pins(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000);
    clock_select(1'b0);                                  // motor stop
    send_pins(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'($urandom));

    // short tape, with one long hold-off on the result side
    wait_drained();
    write_reg(REG_TAPE_LENGTH, 32'd4);
    hold_req <= 1'b1;
    run_tape_traffic(350);

    // zero length acts as one position; upper bits are ignored
    wait_drained();
    write_reg(REG_TAPE_LENGTH, 32'hFFFC_0000);
    run_tape_traffic(200);

    // length beyond the tape clamps; no idling on either side
    wait_drained();
    write_reg(REG_TAPE_LENGTH, 32'h0003_FFFF);
    calm <= 1'b1;
    run_tape_traffic(150);

    // medium tape with a full pause midway
    wait_drained();
    write_reg(REG_TAPE_LENGTH, 32'd20);
    calm <= 1'b0;
    run_tape_traffic(100);
    wait_drained();
    run_tape_traffic(100);

    // tape shortened below the current position
    wait_drained();
    write_reg(REG_TAPE_LENGTH, 32'd2);
    run_tape_traffic(200);

    // cartridge removed: tape wiped, selection reports a gap
    wait_drained();
    write_reg(REG_CARTRIDGE, 32'hFFFF_FFFE);
    clock_select(1'b1);
    clock_select(1'b0);
    run_tape_traffic(150);

    // cartridge inserted again on a three-position tape
    wait_drained();
    write_reg(REG_CARTRIDGE, 32'h0000_0001);
    write_reg(REG_TAPE_LENGTH, 32'd3);
    run_tape_traffic(350);

    // full tape depth
    wait_drained();
    write_reg(REG_TAPE_LENGTH, TAPE_DEPTH);
    run_tape_traffic(150);

    // single position
    wait_drained();
    write_reg(REG_TAPE_LENGTH, 32'd1);
    run_tape_traffic(100);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_cnt == 0 && pending_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- looped_tape_head_model.f -----
src/lth_pkg.sv
src/lth_stream_if.sv
src/lth_tape_ram.sv
src/looped_tape_head_model.sv
tb/sv/lth_checker.sv
tb/sv/tb_looped_tape_head_model.sv
